>>> sv/falu_pkg.sv
`timescale 1ns / 1ps
package falu_pkg;

    // opcodes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MIN  = 4'd4;
    localparam logic [3:0] OP_MAX  = 4'd5;
    localparam logic [3:0] OP_INC  = 4'd6;
    localparam logic [3:0] OP_DEC  = 4'd7;
    localparam logic [3:0] OP_I2F  = 4'd8;
    localparam logic [3:0] OP_F2I  = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DZ   = 2'd2;

    // quotient register width, one sticky bit above it flags overflow
    localparam int QW = 35;

    typedef struct packed {
        logic [31:0] res;
        logic        sat;
    } t_sat;

    // item traveling down the divider chain
    typedef struct packed {
        logic [3:0]    op;
        logic [31:0]   res;
        logic [1:0]    status;
        logic          gt;
        logic          lt;
        logic          eq;
        logic          neg;
        logic          dz;
        logic [31:0]   den;
        logic [31:0]   rem;
        logic [QW-1:0] q;
        logic          ovf;
    } t_meta;

    // clamp to the 32-bit signed range
    function automatic t_sat sat32(input logic signed [64:0] v);
        t_sat s;
        if (v > 65'sh0_7FFF_FFFF) begin
            s.res = 32'h7FFF_FFFF;
            s.sat = 1'b1;
        end else if (v < -65'sh0_8000_0000) begin
            s.res = 32'h8000_0000;
            s.sat = 1'b1;
        end else begin
            s.res = v[31:0];
            s.sat = 1'b0;
        end
        return s;
    endfunction

endpackage

>>> sv/falu_front.sv
`timescale 1ns / 1ps
module falu_front #(
    parameter int FRAC_BITS = 8,
    parameter int DW        = 33 + FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [3:0]           i_op,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output logic                 o_valid,
    output falu_pkg::t_meta      o_meta,
    output logic [DW-1:0]        o_dvd
);
    import falu_pkg::*;

    logic               r_vld;
    logic [3:0]         r_op;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [63:0] r_prod;

    // input register with the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op   <= i_op;
            r_a    <= $signed(i_a);
            r_b    <= $signed(i_b);
            r_prod <= $signed(i_a) * $signed(i_b);
        end
    end

    logic signed [64:0] a65, b65, v;
    logic [63:0]        pmag;
    logic [63:0]        pm;
    logic [31:0]        amag;
    t_sat               s;

    // everything but the divide finishes here
    always_comb begin
        a65  = 65'(r_a);
        b65  = 65'(r_b);
        pmag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
        pm   = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        amag = r_a[31] ? 32'(-r_a) : 32'(r_a);
        v    = '0;
        case (r_op)
            OP_ADD:  v = a65 + b65;
            OP_SUB:  v = a65 - b65;
            OP_MUL:  v = r_prod[63] ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
            OP_INC:  v = a65 + 65'sd1;
            OP_DEC:  v = a65 - 65'sd1;
            OP_I2F:  v = a65 <<< FRAC_BITS;
            default: v = '0;
        endcase
        s = sat32(v);

        o_meta.op     = r_op;
        o_meta.gt     = r_a > r_b;
        o_meta.lt     = r_a < r_b;
        o_meta.eq     = r_a == r_b;
        o_meta.res    = s.res;
        o_meta.status = s.sat ? ST_SAT : ST_OK;
        case (r_op)
            OP_MIN: begin
                o_meta.res    = (r_a < r_b) ? r_a : r_b;
                o_meta.status = ST_OK;
            end
            OP_MAX: begin
                o_meta.res    = (r_a > r_b) ? r_a : r_b;
                o_meta.status = ST_OK;
            end
            OP_F2I: begin
                o_meta.res    = 32'(r_a >>> FRAC_BITS);
                o_meta.status = ST_OK;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_INC, OP_DEC, OP_I2F: ;
            default: begin
                o_meta.res    = '0;
                o_meta.status = ST_OK;
            end
        endcase

        // divider seed: dividend is 2*|a|*2^F
        o_meta.neg = r_a[31] ^ r_b[31];
        o_meta.dz  = (r_b == 32'sd0);
        o_meta.den = r_b[31] ? 32'(-r_b) : 32'(r_b);
        o_meta.rem = '0;
        o_meta.q   = '0;
        o_meta.ovf = 1'b0;
        o_dvd      = {amag, {FRAC_BITS{1'b0}}, 1'b0};
    end

    assign o_valid = r_vld;

endmodule

>>> sv/falu_div_cell.sv
`timescale 1ns / 1ps
module falu_div_cell #(
    parameter int DW = 41
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  falu_pkg::t_meta i_meta,
    input  logic [DW-1:0]   i_dvd,
    output logic            o_valid,
    output falu_pkg::t_meta o_meta,
    output logic [DW-1:0]   o_dvd
);
    import falu_pkg::*;

    logic          r_vld;
    t_meta         r_meta;
    logic [DW-1:0] r_dvd;
    t_meta         n_meta;
    logic [32:0]   trial;
    logic          qbit;

    // one restoring step: bring in the next dividend bit
    always_comb begin
        n_meta = i_meta;
        trial  = {i_meta.rem, i_dvd[DW-1]};
        qbit   = trial >= {1'b0, i_meta.den};
        n_meta.rem = qbit ? 32'(trial - {1'b0, i_meta.den}) : trial[31:0];
        n_meta.q   = {i_meta.q[QW-2:0], qbit};
        n_meta.ovf = i_meta.ovf | i_meta.q[QW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta <= n_meta;
            r_dvd  <= i_dvd << 1;
        end
    end

    assign o_valid = r_vld;
    assign o_meta  = r_meta;
    assign o_dvd   = r_dvd;

endmodule

>>> sv/falu_back.sv
`timescale 1ns / 1ps
module falu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  falu_pkg::t_meta i_meta,
    output logic            o_valid,
    output logic [39:0]     o_data
);
    import falu_pkg::*;

    logic        r_vld;
    logic [39:0] r_data;
    logic [QW:0] m;
    t_sat        s;
    logic [31:0] res;
    logic [1:0]  st;

    // round the doubled quotient: (q + 1) / 2
    always_comb begin
        m   = ({1'b0, i_meta.q} + 1'b1) >> 1;
        s   = sat32(i_meta.neg ? -$signed(65'(m)) : $signed(65'(m)));
        res = i_meta.res;
        st  = i_meta.status;
        if (i_meta.op == OP_DIV) begin
            if (i_meta.dz) begin
                res = '0;
                st  = ST_DZ;
            end else if (i_meta.ovf) begin
                res = i_meta.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                st  = ST_SAT;
            end else begin
                res = s.res;
                st  = s.sat ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= {3'b000, st, i_meta.eq, i_meta.lt, i_meta.gt, res};
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

>>> sv/fixed_point_alu_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake                       payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: op, operand_a, operand_b
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: result, flags, status
// One item per cycle enters while the output is not stalled; the path is the input register,
// one divider cell per dividend bit (FRAC_BITS + 33), then the output register.
// Every item passes the full cell chain so results leave in order.
// A stalled output holds the whole chain; ready follows the output register.
// Synchronous active-low reset clears the valid bits only.
module fixed_point_alu_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // op[3:0], operand_a[35:4], operand_b[67:36]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata   // result[31:0], a_greater[32], a_less[33],
                                         // equal[34], status[36:35]
);
    import falu_pkg::*;

    localparam int DW = 33 + FRAC_BITS;

    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic          vld  [DW+1];
    t_meta         meta [DW+1];
    logic [DW-1:0] dvd  [DW+1];

    falu_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tdata[3:0]),
        .i_a     (i_s_axis_tdata[35:4]),
        .i_b     (i_s_axis_tdata[67:36]),
        .o_valid (vld[0]),
        .o_meta  (meta[0]),
        .o_dvd   (dvd[0])
    );

    // divider cell chain, one quotient bit per cell
    for (genvar g = 0; g < DW; g++) begin : g_cell
        falu_div_cell #(.DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vld[g]),
            .i_meta  (meta[g]),
            .i_dvd   (dvd[g]),
            .o_valid (vld[g+1]),
            .o_meta  (meta[g+1]),
            .o_dvd   (dvd[g+1])
        );
    end

    falu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vld[DW]),
        .i_meta  (meta[DW]),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata)
    );

endmodule

>>> sv/falu_chk.sv
`timescale 1ns / 1ps
module falu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);
    import falu_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // exactly one compare flag
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot(o_m_axis_tdata[34:32]))
        else $error("compare flags not one-hot");

    // no undefined status code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[36:35] != 2'd3)
        else $error("bad status code");

    // divide by zero gives zero
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[36:35] == ST_DZ |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("divide by zero result not zero");

endmodule

bind fixed_point_alu_core falu_chk u_falu_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
